/* rtl/signed_int_to_decimal_ascii_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII converter
// Shared concurrent assertion forms, clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// The condition must never be true outside reset.
`define SITDA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SITDA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Types, constants and the double-dabble step shared by the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

    localparam int VALUE_W         = 32;
    localparam int NUM_DIGITS      = 10;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int LEN_W           = 4;
    localparam int CHAR_W          = 8;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // One value in flight through the binary to BCD conversion.
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        logic               neg;
    } t_dd;

    // One shift-and-add-3 step: correct every BCD digit, then shift left.
    function automatic t_dd dd_step(input t_dd d);
        t_dd r;
        r = d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r.bcd[4*i +: 4] >= 4'd5) begin
                r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
            end
        end
        {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/sitda_dd_stage.sv */
// ----------------------------------------------------------------------------
// sitda_dd_stage
// One register stage of the binary to BCD pipeline, with valid and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_dd_stage #(
    parameter int STEPS     = sitda_pkg::STEPS_PER_STAGE,
    parameter int STAGE_IDX = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire sitda_pkg::t_dd  i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output sitda_pkg::t_dd       o_data
);

    logic           r_valid;
    sitda_pkg::t_dd r_data;
    sitda_pkg::t_dd n_data;

    // Only the steps that fall inside the input width are applied.
    always_comb begin
        n_data = i_data;
        for (int j = 0; j < STEPS; j++) begin
            if (STAGE_IDX * STEPS + j < sitda_pkg::VALUE_W) begin
                n_data = sitda_pkg::dd_step(n_data);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* rtl/sitda_ser.sv */
// ----------------------------------------------------------------------------
// sitda_ser
// Character serializer: turns one BCD value into its ASCII characters.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_ser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire sitda_pkg::t_dd                   i_data,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [sitda_pkg::CHAR_W-1:0]          o_char,
    output logic [sitda_pkg::LEN_W-1:0]           o_len,
    output logic                                  o_last
);

    logic                           r_busy;
    logic                           r_minus;
    logic [sitda_pkg::LEN_W-1:0]    r_left;
    logic [sitda_pkg::LEN_W-1:0]    r_len;
    logic [sitda_pkg::BCD_W-1:0]    r_bcd;

    logic [sitda_pkg::LEN_W-1:0]    ndig;
    logic [sitda_pkg::LEN_W-1:0]    shift_digits;
    logic [sitda_pkg::BCD_W-1:0]    n_bcd;
    logic                           out_xfer;
    logic                           load;

    // Number of significant digits; zero still shows one digit.
    always_comb begin
        ndig = sitda_pkg::LEN_W'(1);
        for (int i = 1; i < sitda_pkg::NUM_DIGITS; i++) begin
            if (i_data.bcd[4*i +: 4] != 4'd0) begin
                ndig = sitda_pkg::LEN_W'(i + 1);
            end
        end
        shift_digits = sitda_pkg::LEN_W'(sitda_pkg::NUM_DIGITS) - ndig;
        n_bcd        = i_data.bcd << {shift_digits, 2'b00};
    end

    assign o_last   = !r_minus && (r_left == sitda_pkg::LEN_W'(1));
    assign out_xfer = r_busy && i_ready;
    assign o_ready  = !r_busy || (out_xfer && o_last);
    assign load     = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (out_xfer && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_minus <= i_data.neg;
            r_left  <= ndig;
            r_len   <= ndig + sitda_pkg::LEN_W'(i_data.neg);
            r_bcd   <= n_bcd;
        end else if (out_xfer) begin
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_left <= r_left - sitda_pkg::LEN_W'(1);
                r_bcd  <= r_bcd << 4;
            end
        end
    end

    assign o_valid = r_busy;
    assign o_char  = r_minus ? sitda_pkg::CHAR_MINUS
                             : sitda_pkg::CHAR_ZERO
                               + sitda_pkg::CHAR_W'(r_bcd[sitda_pkg::BCD_W-1 -: 4]);
    assign o_len   = r_len;

`include "signed_int_to_decimal_ascii_defines.svh"

    `SITDA_ASSERT_NEVER(a_left_nonzero, r_busy && (r_left == '0), "busy with no digits left")
    `SITDA_ASSERT_IMPL(a_len_range, r_busy, (r_len >= r_left) && (r_len <= sitda_pkg::LEN_W'(11)), "text length out of range")
    `SITDA_ASSERT_IMPL(a_digit_ok, r_busy && !r_minus, r_bcd[sitda_pkg::BCD_W-1 -: 4] <= 4'd9, "digit is not decimal")

endmodule

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
// Path: an accepted value is registered in the sign stage, then in each
// double-dabble stage in turn, then loaded into the serializer.
// Throughput: bounded by the single character output of the serializer,
// which sends each value as text of 1 to 11 characters; the conversion pipeline takes one
// value per cycle when the serializer keeps up.
// Reset: synchronous, active low; clears all valid and busy flags.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to decimal ASCII text, one character per
// output transaction, most significant character first.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
    // Double-dabble steps per pipeline stage; sets the pipeline depth.
    parameter int STEPS_PER_STAGE = sitda_pkg::STEPS_PER_STAGE
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input stream. tdata: [31:0] value (signed).
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic signed [31:0] i_s_axis_tdata,
    // Output stream. tdata: [7:0] char_code, [11:8] text_length, [15:12] zero.
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [15:0]             o_m_axis_tdata,
    // tlast carries is_last: high on the final character of a value.
    output logic                    o_m_axis_tlast
);

    localparam int NUM_STAGES =
        (sitda_pkg::VALUE_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Pipeline links; index 0 is the output of the sign stage.
    logic           w_valid [NUM_STAGES+1];
    logic           w_ready [NUM_STAGES+1];
    sitda_pkg::t_dd w_data  [NUM_STAGES+1];

    // Sign stage: the magnitude is formed unsigned, so the most negative
    // value yields 2147483648 without overflow.
    logic           r_sign_valid;
    sitda_pkg::t_dd r_sign_data;
    sitda_pkg::t_dd n_sign_data;

    always_comb begin
        n_sign_data.neg = i_s_axis_tdata[sitda_pkg::VALUE_W-1];
        n_sign_data.bcd = '0;
        n_sign_data.bin = n_sign_data.neg ? (sitda_pkg::VALUE_W'(0) - i_s_axis_tdata)
                                          : i_s_axis_tdata;
    end

    assign o_s_axis_tready = !r_sign_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_sign_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_sign_data <= n_sign_data;
        end
    end

    assign w_valid[0] = r_sign_valid;
    assign w_data[0]  = r_sign_data;

    // Binary to BCD: a chain of shift-and-add-3 stages, each holding one
    // value with its own valid bit and stalling back as the chain fills.
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_dd
        sitda_dd_stage #(
            .STEPS     (STEPS_PER_STAGE),
            .STAGE_IDX (s)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_data  (w_data[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    // The serializer holds one value and sends its characters; it takes
    // the next value in the cycle its last character is accepted.
    logic [sitda_pkg::CHAR_W-1:0] ser_char;
    logic [sitda_pkg::LEN_W-1:0]  ser_len;

    sitda_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_STAGES]),
        .o_ready (w_ready[NUM_STAGES]),
        .i_data  (w_data[NUM_STAGES]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (ser_char),
        .o_len   (ser_len),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, ser_len, ser_char};

endmodule

`default_nettype wire
